/* rtl/core/tms_pkg.sv */
// Shared types and constants for the Markov transition sampler.
`default_nettype none

package tms_pkg;

   // Fixed field widths of the stream payloads
   localparam int IDX_BITS      = 7;
   localparam int FRAC_BITS     = 16;
   localparam int CSR_BITS      = 8;
   localparam int REQ_DATA_BITS = 48;
   localparam int REQ_USER_BITS = 2;
   localparam int RSP_DATA_BITS = 8;
   localparam int RSP_USER_BITS = 2;

   localparam logic [CSR_BITS-1:0] NUM_STATES_RESET = 8'd128;

   // Operation carried in the request tuser
   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_ACC    = 2'd2,
      KIND_SAMPLE = 2'd3
   } kind_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_SMP_HI,
      ST_SMP_LO,
      ST_SMP_MUL,
      ST_SMP_MID,
      ST_SMP_CMP,
      ST_SMP_FB,
      ST_SMP_FE,
      ST_SMP_PICK,
      ST_DONE
   } state_type;

   // Status flags out of the shared arithmetic unit
   typedef struct packed {
      logic sat;   // saturating add clipped at the count maximum
      logic less;  // entry scaled by 2^16 is below the search target
   } alu_flags_type;

endpackage

`default_nettype wire

/* rtl/core/tms_count_ram.sv */
// Single-port-write, single-port-read count table with registered read data.
`default_nettype none

module tms_count_ram #(
   parameter int ADDR_BITS = 14,
   parameter int DATA_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem_ff [0:DEPTH-1];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/tms_alu.sv */
// Shared arithmetic unit: saturating count add and scaled search compare.
`default_nettype none

module tms_alu
   import tms_pkg::*;
#(
   parameter int COUNT_BITS  = 16,
   parameter int TARGET_BITS = 34
) (
   input  wire logic        [COUNT_BITS-1:0]  entry,
   input  wire logic        [COUNT_BITS-1:0]  addend,
   input  wire logic signed [TARGET_BITS-1:0] target,
   output logic             [COUNT_BITS-1:0]  result,
   output alu_flags_type                      flags
);

   logic        [COUNT_BITS:0]    sum;
   logic signed [TARGET_BITS-1:0] scaled;

   // saturating add: carry out means the sum passed the count maximum;
   // exact compare of entry * 2^16 against fraction * difference
   always_comb begin
      sum        = {1'b0, entry} + {1'b0, addend};
      flags.sat  = sum[COUNT_BITS];
      result     = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
      scaled     = $signed({2'b00, entry, {FRAC_BITS{1'b0}}});
      flags.less = scaled < target;
   end

endmodule

`default_nettype wire

/* rtl/core/markov_transition_sampler.sv */
// Top level: transaction sequencer over the count table and the shared unit.
`default_nettype none

// Keeps a MAX_STATES x MAX_STATES table of saturating transition counts in one
// memory and handles one request transaction at a time; req_tready is high only
// while the sequencer is idle, and one response is returned per request. Each
// memory read presents the address, then gets the registered data. Clear sweeps
// the whole memory one entry a cycle; the same sweep runs after reset before the
// first request is taken. Add reads an entry, then writes it back incremented.
// Accumulate walks n x n entries, n the clamped num_states. Sample does at most
// ceil(log2(high_col - low_col)) binary search steps and is bound by the
// read-compare loop through the memory port; a sample with an empty range goes
// straight to the response. A new request may be accepted while the previous
// response still waits on rsp_tready.
module markov_transition_sampler
   import tms_pkg::*;
#(
   parameter int MAX_STATES = 128,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // configuration: num_states
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_BITS-1:0]      csr_wr_data,
   // request: tdata = from_state[6:0], to_state[13:7], low_col[20:14],
   //          high_col[27:21], rand_fraction[43:28], zero fill [47:44]
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // request tuser = kind[1:0]
   input  wire logic [REQ_USER_BITS-1:0] req_tuser,
   // response: tdata = next_state[6:0], zero fill [7]
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   // response tuser = range_error[0], count_saturated[1]
   output logic      [RSP_USER_BITS-1:0] rsp_tuser
);

   localparam int IW = $clog2(MAX_STATES);      // row or column address bits
   localparam int AW = 2 * IW;                  // memory address bits
   localparam int NW = IW + 1;                  // holds a state count up to MAX_STATES
   localparam int TW = COUNT_BITS + FRAC_BITS + 2; // signed search target width

   // registers
   state_type               state_ff, state_in;
   logic [CSR_BITS-1:0]     csr_ff;
   logic [AW-1:0]           clr_cnt_ff, clr_cnt_in;
   logic                    clr_reply_ff, clr_reply_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_BITS-1:0] rsp_tuser_ff, rsp_tuser_in;
   logic [IDX_BITS-1:0]     from_ff, from_in;
   logic [IDX_BITS-1:0]     to_ff, to_in;
   logic [IDX_BITS-1:0]     hi_ff, hi_in;
   logic [FRAC_BITS-1:0]    frac_ff, frac_in;
   logic [IDX_BITS-1:0]     b_ff, b_in;
   logic [IDX_BITS-1:0]     e_ff, e_in;
   logic [NW-1:0]           r_ff, r_in;
   logic [NW-1:0]           c_ff, c_in;
   logic [COUNT_BITS-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0]   hold_ff, hold_in;
   logic signed [TW-1:0]    target_ff, target_in;
   logic                    zero_ff, zero_in;
   logic [IDX_BITS-1:0]     next_ff, next_in;
   logic                    err_ff, err_in;
   logic                    sat_ff, sat_in;

   // combinational
   logic                    req_fire;
   logic                    rsp_free;
   logic [NW-1:0]           n_eff;
   logic [IDX_BITS-1:0]     req_from, req_to, req_lo, req_hi;
   logic [FRAC_BITS-1:0]    req_frac;
   logic [IDX_BITS:0]       be_sum;
   logic [IDX_BITS-1:0]     mid;
   logic                    search_more;
   logic                    row_last, col_last;
   logic [COUNT_BITS-1:0]   ram_rd_data;
   logic [COUNT_BITS-1:0]   entry;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [COUNT_BITS-1:0]   ram_wr_data;
   logic [AW-1:0]           ram_rd_addr;
   logic [COUNT_BITS-1:0]   alu_addend;
   logic [COUNT_BITS-1:0]   alu_result;
   alu_flags_type           alu_flags;
   logic signed [COUNT_BITS:0] diff;
   logic signed [FRAC_BITS:0]  frac_s;
   logic signed [TW-1:0]    product;

   // request field unpacking
   assign req_from = req_tdata[6:0];
   assign req_to   = req_tdata[13:7];
   assign req_lo   = req_tdata[20:14];
   assign req_hi   = req_tdata[27:21];
   assign req_frac = req_tdata[43:28];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // states in use, clamped to 1..MAX_STATES
   always_comb begin
      if (csr_ff == '0) begin
         n_eff = NW'(1);
      end else if (int'(csr_ff) > MAX_STATES) begin
         n_eff = NW'(MAX_STATES);
      end else begin
         n_eff = NW'(csr_ff);
      end
   end

   // binary search step
   assign be_sum      = {1'b0, b_ff} + {1'b0, e_ff};
   assign mid         = be_sum[IDX_BITS:1];
   assign search_more = ({1'b0, b_ff} + (IDX_BITS + 1)'(1)) < {1'b0, e_ff};

   // accumulate walk bounds
   assign col_last = (c_ff + NW'(1)) >= n_eff;
   assign row_last = (r_ff + NW'(1)) >= n_eff;

   // entries outside the table read as zero
   assign entry = zero_ff ? '0 : ram_rd_data;

   // search target: fraction times (E(high) - E(low)), 17 x 17 signed product
   assign diff    = $signed({1'b0, hold_ff}) - $signed({1'b0, entry});
   assign frac_s  = $signed({1'b0, frac_ff});
   assign product = frac_s * diff;

   tms_count_ram #(
      .ADDR_BITS (AW),
      .DATA_BITS (COUNT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tms_alu #(
      .COUNT_BITS  (COUNT_BITS),
      .TARGET_BITS (TW)
   ) u_alu (
      .entry  (entry),
      .addend (alu_addend),
      .target (target_ff),
      .result (alu_result),
      .flags  (alu_flags)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (kind_type'(req_tuser))
                  KIND_CLEAR: state_in = ST_CLEAR;
                  KIND_ADD: begin
                     if ((req_from < n_eff) && (req_to < n_eff)) begin
                        state_in = ST_ADD_RD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  KIND_ACC: state_in = ST_ACC_RD;
                  KIND_SAMPLE: begin
                     if (req_lo >= req_hi) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SMP_HI;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (&clr_cnt_ff) begin
               state_in = clr_reply_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_ADD_RD:   state_in = ST_ADD_WR;
         ST_ADD_WR:   state_in = ST_DONE;
         ST_ACC_RD:   state_in = ST_ACC_WR;
         ST_ACC_WR: begin
            if (col_last && row_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ACC_RD;
            end
         end
         ST_SMP_HI:   state_in = ST_SMP_LO;
         ST_SMP_LO:   state_in = ST_SMP_MUL;
         ST_SMP_MUL:  state_in = ST_SMP_MID;
         ST_SMP_MID:  state_in = search_more ? ST_SMP_CMP : ST_SMP_FB;
         ST_SMP_CMP:  state_in = ST_SMP_MID;
         ST_SMP_FB:   state_in = ST_SMP_FE;
         ST_SMP_FE:   state_in = ST_SMP_PICK;
         ST_SMP_PICK: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      clr_reply_in  = clr_reply_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      hi_in         = hi_ff;
      frac_in       = frac_ff;
      b_in          = b_ff;
      e_in          = e_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      sum_in        = sum_ff;
      hold_in       = hold_ff;
      target_in     = target_ff;
      zero_in       = 1'b0;
      next_in       = next_ff;
      err_in        = err_ff;
      sat_in        = sat_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = {IW'(from_ff), IW'(to_ff)};
      ram_wr_data   = alu_result;
      ram_rd_addr   = {IW'(from_ff), IW'(to_ff)};
      alu_addend    = sum_ff;

      unique case (state_ff)
         // latch the request and set up the run
         ST_IDLE: begin
            if (req_fire) begin
               from_in      = req_from;
               to_in        = req_to;
               b_in         = req_lo;
               e_in         = req_hi;
               hi_in        = req_hi;
               frac_in      = req_frac;
               r_in         = '0;
               c_in         = '0;
               sum_in       = '0;
               clr_cnt_in   = '0;
               clr_reply_in = 1'b1;
               next_in      = '0;
               sat_in       = 1'b0;
               err_in       = (kind_type'(req_tuser) == KIND_SAMPLE) && (req_lo >= req_hi);
            end
         end
         // zero sweep over the whole memory
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + AW'(1);
         end
         // add: read, then write back incremented with saturation
         ST_ADD_RD: begin
            ram_rd_addr = {IW'(from_ff), IW'(to_ff)};
         end
         ST_ADD_WR: begin
            alu_addend  = COUNT_BITS'(1);
            ram_wr_en   = 1'b1;
            ram_wr_addr = {IW'(from_ff), IW'(to_ff)};
            sat_in      = alu_flags.sat;
         end
         // accumulate: running sum along each row
         ST_ACC_RD: begin
            ram_rd_addr = {r_ff[IW-1:0], c_ff[IW-1:0]};
         end
         ST_ACC_WR: begin
            alu_addend  = sum_ff;
            ram_wr_en   = 1'b1;
            ram_wr_addr = {r_ff[IW-1:0], c_ff[IW-1:0]};
            sat_in      = sat_ff || alu_flags.sat;
            if (col_last) begin
               c_in   = '0;
               sum_in = '0;
               r_in   = r_ff + NW'(1);
            end else begin
               c_in   = c_ff + NW'(1);
               sum_in = alu_result;
            end
         end
         // sample: fetch both range ends, form the target
         ST_SMP_HI: begin
            ram_rd_addr = {IW'(from_ff), IW'(hi_ff)};
            zero_in     = (from_ff >= MAX_STATES) || (hi_ff >= MAX_STATES);
         end
         ST_SMP_LO: begin
            hold_in     = entry;
            ram_rd_addr = {IW'(from_ff), IW'(b_ff)};
            zero_in     = (from_ff >= MAX_STATES) || (b_ff >= MAX_STATES);
         end
         ST_SMP_MUL: begin
            target_in = product;
         end
         // one search step: read the midpoint, then narrow the range
         ST_SMP_MID: begin
            if (search_more) begin
               ram_rd_addr = {IW'(from_ff), IW'(mid)};
               zero_in     = (from_ff >= MAX_STATES) || (mid >= MAX_STATES);
               hold_in     = COUNT_BITS'(mid);
            end
         end
         ST_SMP_CMP: begin
            if (alu_flags.less) begin
               b_in = mid;
            end else begin
               e_in = mid;
            end
         end
         // final pick between the lower neighbour and the upper end
         ST_SMP_FB: begin
            ram_rd_addr = {IW'(from_ff), IW'(b_ff)};
            zero_in     = (from_ff >= MAX_STATES) || (b_ff >= MAX_STATES);
         end
         ST_SMP_FE: begin
            hold_in     = entry;
            ram_rd_addr = {IW'(from_ff), IW'(e_ff)};
            zero_in     = (from_ff >= MAX_STATES) || (e_ff >= MAX_STATES);
         end
         ST_SMP_PICK: begin
            next_in = (hold_ff == entry) ? b_ff : e_ff;
         end
         // hand the result to the output register once it is free
         ST_DONE: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, next_ff};
               rsp_tuser_in  = {sat_ff, err_ff};
            end
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         clr_reply_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         csr_ff        <= NUM_STATES_RESET;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_reply_ff  <= clr_reply_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      from_ff      <= from_in;
      to_ff        <= to_in;
      hi_ff        <= hi_in;
      frac_ff      <= frac_in;
      b_ff         <= b_in;
      e_ff         <= e_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      sum_ff       <= sum_in;
      hold_ff      <= hold_in;
      target_ff    <= target_in;
      zero_ff      <= zero_in;
      next_ff      <= next_in;
      err_ff       <= err_in;
      sat_ff       <= sat_in;
   end

endmodule

`default_nettype wire

/* test/tb_markov_transition_sampler.sv */
// Self-checking testbench for the Markov transition sampler: request stream, response checks.
module tb_markov_transition_sampler;
   import tms_pkg::*;

   localparam int TABLE_DIM    = 128;
   localparam int COUNT_W      = 16;
   localparam int COUNT_TOP    = (1 << COUNT_W) - 1;
   localparam int STALL_LIMIT  = 150000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_CAP    = 40;
   localparam int EXP_DEPTH    = 16;

   // One expected response, tagged with the request kind for messages
   typedef struct {
      kind_type   kind;
      bit [6:0]   next_state;
      bit         range_error;
      bit         count_saturated;
   } transition_result_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_BITS-1:0]      csr_wr_data;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [REQ_USER_BITS-1:0] req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;

   // Mirror of the count table and the num_states register
   bit [COUNT_W-1:0]      count_mirror [0:TABLE_DIM*TABLE_DIM-1];
   bit [7:0]              states_setting = 8'd128;
   // Ring of expected responses, oldest at the read pointer
   transition_result_type expected_fifo [0:EXP_DEPTH-1];
   int unsigned           exp_wr_ptr = 0;
   int unsigned           exp_rd_ptr = 0;
   transition_result_type oldest;

   bit          send_idle_en = 1'b1;
   bit          recv_idle_en = 1'b1;
   bit          hold_req     = 1'b0;
   int unsigned error_count  = 0;
   int unsigned rsp_checked  = 0;
   int unsigned err_seen     = 0;
   int unsigned sat_seen     = 0;
   int unsigned cfg_writes   = 0;
   int unsigned kind_seen [4];

   markov_transition_sampler #(
      .MAX_STATES(TABLE_DIM),
      .COUNT_BITS(COUNT_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic int unsigned clamp_states(bit [7:0] v);
      if (v == 8'd0) return 1;
      if (v > TABLE_DIM) return TABLE_DIM;
      return int'(v);
   endfunction

   function automatic longint mirror_entry(int unsigned row, int unsigned col);
      return longint'(count_mirror[row*TABLE_DIM + col]);
   endfunction

   // Binary search over running sums; exact compare of entry*2^16 against frac*span
   function automatic bit [6:0] search_row(int unsigned row, int unsigned lo,
                                           int unsigned hi, bit [15:0] frac);
      longint      span;
      longint      target;
      int unsigned b;
      int unsigned e;
      int unsigned m;
      span   = mirror_entry(row, hi) - mirror_entry(row, lo);
      target = longint'(frac) * span;
      b = lo;
      e = hi;
      m = (lo + hi) / 2;
      while (b + 1 < e) begin
         if (mirror_entry(row, m) * 65536 < target) b = m;
         else e = m;
         m = (b + e) / 2;
      end
      // equal neighbours: take the lower one
      if (mirror_entry(row, m) == mirror_entry(row, e)) return 7'(m);
      return 7'(e);
   endfunction

   function automatic transition_result_type predict_transition(
      kind_type kind, bit [6:0] fr, bit [6:0] to, bit [6:0] lo, bit [6:0] hi,
      bit [15:0] frac);
      transition_result_type res;
      int unsigned        n;
      int unsigned        idx;
      longint             sum;
      res.kind            = kind;
      res.next_state      = '0;
      res.range_error     = 1'b0;
      res.count_saturated = 1'b0;
      n = clamp_states(states_setting);
      case (kind)
         KIND_CLEAR: begin
            foreach (count_mirror[i]) count_mirror[i] = '0;
         end
         KIND_ADD: begin
            if (fr < n && to < n) begin
               idx = fr * TABLE_DIM + to;
               if (count_mirror[idx] == COUNT_TOP) res.count_saturated = 1'b1;
               else count_mirror[idx] = count_mirror[idx] + 1'b1;
            end
         end
         KIND_ACC: begin
            for (int r = 0; r < n; r++) begin
               sum = 0;
               for (int c = 0; c < n; c++) begin
                  sum = sum + mirror_entry(r, c);
                  if (sum > COUNT_TOP) begin
                     sum = COUNT_TOP;
                     res.count_saturated = 1'b1;
                  end
                  count_mirror[r*TABLE_DIM + c] = sum[COUNT_W-1:0];
               end
            end
         end
         default: begin
            if (lo >= hi) res.range_error = 1'b1;
            else res.next_state = search_row(fr, lo, hi, frac);
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- reporting
   task automatic report_mismatch(string what, int unsigned got, int unsigned want,
                                  kind_type kind);
      if (error_count < PRINT_CAP)
         $display("ERROR: response %0d (%s): %s got %0d expected %0d",
                  rsp_checked, kind.name(), what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------- request side
   task automatic send_item(kind_type kind, bit [6:0] fr, bit [6:0] to, bit [6:0] lo,
                            bit [6:0] hi, bit [15:0] frac);
      if (send_idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, frac, hi, lo, to, fr};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      kind_seen[kind]++;
      expected_fifo[exp_wr_ptr % EXP_DEPTH] = predict_transition(kind, fr, to, lo, hi, frac);
      exp_wr_ptr++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   // Register writes only with the block idle and nothing outstanding
   task automatic write_num_states(bit [7:0] v);
      stop_sending();
      while (exp_wr_ptr != exp_rd_ptr) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      states_setting = v;
      cfg_writes++;
   endtask

   // Mostly well-formed traffic: adds on a hot row, in-range searches, rare clears
   task automatic send_random_item(int unsigned n, bit [6:0] hot_row);
      int unsigned pick;
      bit [6:0]    fr;
      bit [6:0]    to;
      bit [6:0]    lo;
      bit [6:0]    hi;
      bit [15:0]   frac;
      kind_type    kind;
      fr   = 7'($urandom);
      to   = 7'($urandom);
      lo   = 7'($urandom);
      hi   = 7'($urandom);
      frac = 16'($urandom);
      pick = $urandom_range(0, 999);
      if (pick < 3) begin
         kind = KIND_CLEAR;
      end else if (pick < ((n <= 32) ? 40 : 9)) begin
         kind = KIND_ACC;
      end else if (pick < 500) begin
         kind = KIND_ADD;
         if ($urandom_range(0, 9) != 0) begin
            fr = ($urandom_range(0, 9) < 7) ? hot_row : 7'($urandom_range(0, n - 1));
            to = 7'($urandom_range(0, n - 1));
         end
      end else begin
         kind = KIND_SAMPLE;
         pick = $urandom_range(0, 99);
         if (pick < 70 && n >= 2) begin
            lo = 7'($urandom_range(0, n - 2));
            hi = 7'($urandom_range(lo + 1, n - 1));
         end else if (pick < 85) begin
            // empty range, low not below high
            hi = 7'($urandom_range(0, 127));
            lo = 7'($urandom_range(hi, 127));
         end
         if ($urandom_range(0, 9) < 6) fr = hot_row;
         case ($urandom_range(0, 9))
            0:       frac = '0;
            1:       frac = '1;
            default: ;
         endcase
      end
      send_item(kind, fr, to, lo, hi, frac);
   endtask

   // ---------------------------------------------------------------- response side
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            // long hold-off so the block fills and stops taking requests
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (recv_idle_en && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_wr_ptr == exp_rd_ptr) begin
            report_mismatch("response with nothing pending", rsp_tdata, 0, KIND_CLEAR);
         end else begin
            oldest = expected_fifo[exp_rd_ptr % EXP_DEPTH];
            exp_rd_ptr++;
            if (rsp_tdata !== {1'b0, oldest.next_state})
               report_mismatch("next_state", rsp_tdata, oldest.next_state, oldest.kind);
            if (rsp_tuser[0] !== oldest.range_error)
               report_mismatch("range_error", rsp_tuser[0], oldest.range_error, oldest.kind);
            if (rsp_tuser[1] !== oldest.count_saturated)
               report_mismatch("count_saturated", rsp_tuser[1], oldest.count_saturated,
                               oldest.kind);
            err_seen += oldest.range_error;
            sat_seen += oldest.count_saturated;
         end
         rsp_checked++;
      end
   end

   // Watchdog: cycles without any transaction on either side
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- tests
   // Full-size table: search edges, running sums, saturation, equal neighbours
   task automatic test_directed_counts();
      send_item(KIND_ADD, 0, 0, 0, 0, 0);
      send_item(KIND_ADD, 127, 127, 0, 0, 0);
      send_item(KIND_ADD, 0, 5, 0, 0, 0);
      send_item(KIND_SAMPLE, 0, 0, 0, 127, 16'hFFFF);
      send_item(KIND_ACC, 0, 0, 0, 0, 0);
      send_item(KIND_ACC, 0, 0, 0, 0, 0);
      send_item(KIND_SAMPLE, 0, 0, 0, 127, 16'hFFFF);
      send_item(KIND_SAMPLE, 0, 0, 0, 1, 16'h8000);
      send_item(KIND_SAMPLE, 0, 0, 5, 5, 16'h1234);
      send_item(KIND_SAMPLE, 0, 0, 100, 3, 16'h1234);
      send_item(KIND_ACC, 0, 0, 0, 0, 0);
      send_item(KIND_ACC, 0, 0, 0, 0, 0);
      send_item(KIND_ADD, 0, 127, 0, 0, 0);
      send_item(KIND_SAMPLE, 0, 0, 100, 127, 16'($urandom));
      send_item(KIND_SAMPLE, 127, 0, 0, 127, 16'h4000);
   endtask

   // Falling row: a high-column count below the low-column count gives a negative span
   task automatic test_negative_span();
      send_item(KIND_CLEAR, 0, 0, 0, 0, 0);
      send_item(KIND_ADD, 5, 10, 0, 0, 0);
      send_item(KIND_ADD, 5, 10, 0, 0, 0);
      send_item(KIND_SAMPLE, 5, 0, 10, 20, 16'hFFFF);
   endtask

   // Small tables: out-of-range adds and searches past the active size
   task automatic test_small_table();
      write_num_states(8'd3);
      send_item(KIND_ADD, 3, 0, 0, 0, 0);
      send_item(KIND_ADD, 0, 3, 0, 0, 0);
      send_item(KIND_ADD, 2, 2, 0, 0, 0);
      send_item(KIND_ACC, 0, 0, 0, 0, 0);
      send_item(KIND_SAMPLE, 2, 0, 0, 127, 16'hFFFF);
      write_num_states(8'd0);
      send_item(KIND_ADD, 0, 0, 0, 0, 0);
      send_item(KIND_ADD, 1, 0, 0, 0, 0);
      send_item(KIND_ACC, 0, 0, 0, 0, 0);
   endtask

   // Phases of random traffic, each with its own table size
   task automatic test_random_traffic(int unsigned total);
      int unsigned sent;
      int unsigned phase_len;
      int unsigned n;
      bit [7:0]    setting;
      bit [6:0]    hot_row;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(0, 9))
            0:       setting = 8'd0;
            1:       setting = 8'd1;
            2:       setting = 8'd2;
            3:       setting = 8'd128;
            4:       setting = 8'd255;
            5:       setting = 8'($urandom_range(129, 255));
            6:       setting = 8'($urandom_range(0, 255));
            default: setting = 8'($urandom_range(3, 16));
         endcase
         write_num_states(setting);
         n         = clamp_states(setting);
         hot_row   = 7'($urandom_range(0, n - 1));
         phase_len = $urandom_range(60, 140);
         repeat (phase_len) send_random_item(n, hot_row);
         sent += phase_len;
      end
   endtask

   // Receiver holds off while requests keep coming
   task automatic test_output_backpressure();
      write_num_states(8'd8);
      send_idle_en = 1'b0;
      hold_req     = 1'b1;
      repeat (24) send_random_item(8, 7'($urandom_range(0, 7)));
      send_idle_en = 1'b1;
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_streaming_tail(int unsigned count);
      write_num_states(8'($urandom_range(2, 16)));
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      repeat (count) send_random_item(clamp_states(states_setting),
                                      7'($urandom_range(0, clamp_states(states_setting) - 1)));
   endtask

   initial begin
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= KIND_CLEAR;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_counts();
      test_negative_span();
      test_small_table();
      test_random_traffic(1200);
      test_output_backpressure();
      test_streaming_tail(150);

      stop_sending();
      while (exp_wr_ptr != exp_rd_ptr) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d clears, %0d adds, %0d accumulates, %0d samples over %0d sizes",
               kind_seen[KIND_CLEAR], kind_seen[KIND_ADD], kind_seen[KIND_ACC],
               kind_seen[KIND_SAMPLE], cfg_writes);
      $display("Checked %0d responses: %0d empty ranges, %0d saturating, %0d mismatches",
               rsp_checked, err_seen, sat_seen, error_count);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
